// ===== design/sliding_cross_correlator_core_defines.svh =====
// Assertion macros for the sliding cross-correlator RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef SLIDING_CROSS_CORRELATOR_CORE_DEFINES_SVH
`define SLIDING_CROSS_CORRELATOR_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// Check prop at every rising clock edge outside reset.
`define SCC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check prop at every rising clock edge, reset included.
`define SCC_ASSERT_AT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SCC_ASSERT(lbl, clk, rst_n, prop, msg)
`define SCC_ASSERT_AT(lbl, clk, prop, msg)
`endif
`endif

// ===== design/scc_pkg.sv =====
// Shared constants and types for the sliding cross-correlator.
// No dependencies; used by the interfaces, scc_mac and the top level.
`timescale 1ns / 1ps
`default_nettype none

package scc_pkg;

  localparam int FUNC_W  = 1;
  localparam int IDX_W   = 6;
  localparam int VALUE_W = 16;
  localparam int LEN_W   = 7;
  localparam int CORR_W  = 38;

  localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;

  localparam logic [FUNC_W-1:0] FUNC_TAP    = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 1'b1;

  // Control word that travels with one product through the MAC pipeline.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

  // Status returned by the MAC unit.
  typedef struct packed {
    logic busy;
    logic done;
  } mac_sts_t;

endpackage

`default_nettype wire

// ===== design/scc_if.sv =====
// Valid/ready channel interfaces for the sliding cross-correlator.
// Depends on scc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface scc_in_if;
  logic                        valid;
  logic                        ready;
  logic [scc_pkg::FUNC_W-1:0]  func;
  logic [scc_pkg::IDX_W-1:0]   tap_index;
  logic [scc_pkg::VALUE_W-1:0] value;
  logic                        start_req;

  modport source (output valid, func, tap_index, value, start_req, input ready);
  modport sink   (input valid, func, tap_index, value, start_req, output ready);
endinterface

interface scc_out_if;
  logic                       valid;
  logic                       ready;
  logic [scc_pkg::CORR_W-1:0] correlation;

  modport source (output valid, correlation, input ready);
  modport sink   (input valid, correlation, output ready);
endinterface

interface scc_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [scc_pkg::LEN_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== design/scc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module scc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/scc_cell.sv =====
// One cell of the sample chain: a window sample and a work copy.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module scc_cell #(
  parameter int W = 16
) (
  input  wire logic         clk,
  input  wire logic         load,
  input  wire logic         sweep,
  input  wire logic [W-1:0] win_in,
  input  wire logic [W-1:0] work_in,
  output logic      [W-1:0] win_q,
  output logic      [W-1:0] work_q
);

  logic [W-1:0] win_r;
  logic [W-1:0] work_r;

  // Load shifts the window by one; sweep moves the work copy toward cell 0.
  always_ff @(posedge clk) begin
    if (load) begin
      win_r  <= win_in;
      work_r <= win_in;
    end else if (sweep) begin
      work_r <= work_in;
    end
  end

  assign win_q  = win_r;
  assign work_q = work_r;

endmodule

`default_nettype wire

// ===== design/scc_mac.sv =====
// Two-stage multiply-accumulate unit: product register, then accumulator.
// Depends on scc_pkg for the control and status structs.
`timescale 1ns / 1ps
`default_nettype none

module scc_mac #(
  parameter int SAMPLE_BITS = 16,
  parameter int ACC_W       = 39
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire scc_pkg::mac_ctl_t      ctl,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  input  wire logic [SAMPLE_BITS-1:0] tap,
  output logic      [ACC_W-1:0]       acc,
  output scc_pkg::mac_sts_t           sts
);

  localparam int PW = 2 * SAMPLE_BITS;

  scc_pkg::mac_ctl_t ctl1_r;
  logic [PW-1:0]     prod_r;
  logic [PW-1:0]     prod_nxt;
  logic [ACC_W-1:0]  acc_r;
  logic [ACC_W-1:0]  acc_nxt;

  assign prod_nxt = PW'(sample) * PW'(tap);
  assign acc_nxt  = (ctl1_r.first ? '0 : acc_r) + ACC_W'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
    end else begin
      ctl1_r <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (ctl1_r.valid) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc      = acc_r;
  assign sts.busy = ctl1_r.valid;
  assign sts.done = ctl1_r.valid && ctl1_r.last;

endmodule

`default_nettype wire

// ===== design/sliding_cross_correlator_core.sv =====
// Sliding-window cross-correlator top level: sample cell chain, tap RAM, MAC.
// Depends on scc_pkg, scc_if, scc_ram, scc_cell, scc_mac and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "sliding_cross_correlator_core_defines.svh"

// Channel   Dir  Payload                                  Transaction
// in_ch     in   func, tap_index, value, start_req        tap load or sample
// out_ch    out  correlation                              one result
// cfg_ch    in   data (template_length)                   register write
//
// A sample that gives a result holds off the next transaction while the taps
// of the clamped template length L are read one per cycle from the single
// read port of the tap RAM and pass through the registered tap read, the
// product and accumulate registers and the hand-over into the output register.
// Reset (rst_n low, synchronous) clears the fill count, the sequencer and the
// output valid, and sets template_length to 64; the tap RAM is not cleared.
// in_ch stalls while a result is computed or waits for the output register;
// a result held in out_ch does not block the next transaction.
module sliding_cross_correlator_core #(
  parameter int MAX_TAPS    = 64,
  parameter int SAMPLE_BITS = 16
) (
  input wire logic  clk,
  input wire logic  rst_n,
  scc_in_if.sink    in_ch,
  scc_out_if.source out_ch,
  scc_cfg_if.sink   cfg_ch
);

  localparam int CNT_W = $clog2(MAX_TAPS + 1);
  localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int ACC_W = 2 * SAMPLE_BITS + $clog2(MAX_TAPS) + 1;
  localparam int CW    = scc_pkg::CORR_W;
  localparam int LW    = scc_pkg::LEN_W;

  // Configuration and sequencing state.
  logic [LW-1:0]    cfg_len_r;
  logic [CNT_W-1:0] fill_r;
  logic [CNT_W-1:0] fill_base;
  logic [CNT_W-1:0] fill_nxt;
  logic [CNT_W-1:0] eff_len;
  logic [CNT_W-1:0] len_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             pend_r;
  logic             out_valid_r;
  logic [CW-1:0]    out_data_r;

  logic                   in_ready;
  logic                   in_fire;
  logic                   smp_fire;
  logic                   tap_we;
  logic                   fire_result;
  logic                   sweep_last;
  logic                   out_load;
  logic [SAMPLE_BITS-1:0] sample;
  logic [AW-1:0]          raddr;
  logic [SAMPLE_BITS-1:0] tap_q;
  logic [SAMPLE_BITS-1:0] s_d_r;
  scc_pkg::mac_ctl_t      ctl_d_r;
  scc_pkg::mac_sts_t      mac_sts;
  logic [ACC_W-1:0]       acc;

  logic [SAMPLE_BITS-1:0] win_w  [MAX_TAPS];
  logic [SAMPLE_BITS-1:0] work_w [MAX_TAPS];

  // Only the low SAMPLE_BITS bits of value take part.
  assign sample = SAMPLE_BITS'(in_ch.value);

  // Hold off new transactions until the running result has left the MAC.
  assign in_ready    = !busy_r && !ctl_d_r.valid && !mac_sts.busy && !pend_r;
  assign in_ch.ready = in_ready;
  assign in_fire     = in_ch.valid && in_ready;
  assign smp_fire    = in_fire && (in_ch.func == scc_pkg::FUNC_SAMPLE);
  // Drop tap loads whose index lies beyond the template store.
  assign tap_we      = in_fire && (in_ch.func == scc_pkg::FUNC_TAP) &&
                       (32'(in_ch.tap_index) < MAX_TAPS);

  assign cfg_ch.ready = 1'b1;

  // Clamp the programmed length into 1..MAX_TAPS.
  always_comb begin
    if (cfg_len_r == '0) begin
      eff_len = CNT_W'(1);
    end else if (32'(cfg_len_r) > 32'(MAX_TAPS)) begin
      eff_len = CNT_W'(MAX_TAPS);
    end else begin
      eff_len = CNT_W'(cfg_len_r);
    end
  end

  // A start request restarts the count before this sample is counted;
  // the count saturates at MAX_TAPS.
  always_comb begin
    fill_base = in_ch.start_req ? '0 : fill_r;
    fill_nxt  = (32'(fill_base) < MAX_TAPS) ? fill_base + CNT_W'(1) : fill_base;
  end

  assign fire_result = smp_fire && (fill_nxt >= eff_len);

  // Sweep step t pairs window[t] (arriving at cell 0) with tap[L-1-t].
  assign sweep_last = (cnt_r == len_r - CNT_W'(1));
  assign raddr      = AW'(len_r - CNT_W'(1) - cnt_r);

  assign out_load = pend_r && (!out_valid_r || out_ch.ready);

  // Sample chain: the window shifts on every sample, the work copy sweeps.
  for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
    logic [SAMPLE_BITS-1:0] win_in;
    logic [SAMPLE_BITS-1:0] work_in;

    if (i == 0) begin : g_head
      assign win_in = sample;
    end else begin : g_body
      assign win_in = win_w[i-1];
    end

    if (i == MAX_TAPS - 1) begin : g_tail
      assign work_in = '0;
    end else begin : g_link
      assign work_in = work_w[i+1];
    end

    scc_cell #(
      .W (SAMPLE_BITS)
    ) u_cell (
      .clk     (clk),
      .load    (smp_fire),
      .sweep   (busy_r),
      .win_in  (win_in),
      .work_in (work_in),
      .win_q   (win_w[i]),
      .work_q  (work_w[i])
    );
  end

  scc_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_TAPS)
  ) u_taps (
    .clk   (clk),
    .we    (tap_we),
    .waddr (AW'(in_ch.tap_index)),
    .wdata (sample),
    .raddr (raddr),
    .rdata (tap_q)
  );

  scc_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ACC_W       (ACC_W)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl_d_r),
    .sample (s_d_r),
    .tap    (tap_q),
    .acc    (acc),
    .sts    (mac_sts)
  );

  // Control state and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r   <= scc_pkg::LEN_RESET;
      fill_r      <= '0;
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      len_r       <= '0;
      ctl_d_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        cfg_len_r <= cfg_ch.data;
      end

      if (smp_fire) begin
        fill_r <= fill_nxt;
      end

      // Start a sweep on a sample that completes a window; advance otherwise.
      if (fire_result) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        len_r  <= eff_len;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (sweep_last) begin
          busy_r <= 1'b0;
        end
      end

      // Align the control word with the registered tap read.
      ctl_d_r.valid <= busy_r;
      ctl_d_r.first <= busy_r && (cnt_r == '0);
      ctl_d_r.last  <= busy_r && sweep_last;

      // Hold the finished sum in the accumulator until the output takes it.
      if (mac_sts.done) begin
        pend_r <= 1'b1;
      end else if (out_load) begin
        pend_r <= 1'b0;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s_d_r <= work_w[0];
    if (out_load) begin
      out_data_r <= CW'(acc);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.correlation = out_data_r;

  `SCC_ASSERT(a_no_accept_in_sweep, clk, rst_n, busy_r |-> !in_ch.ready, "transaction accepted during sweep")
  `SCC_ASSERT(a_cnt_within_len, clk, rst_n, busy_r |-> (cnt_r < len_r), "sweep count beyond template length")
  `SCC_ASSERT(a_fill_saturates, clk, rst_n, 32'(fill_r) <= MAX_TAPS, "fill count beyond MAX_TAPS")
  `SCC_ASSERT(a_out_from_pending, clk, rst_n, $rose(out_valid_r) |-> $past(pend_r), "result without a finished sum")
  `SCC_ASSERT_AT(a_reset_idle, clk, !rst_n |=> (!busy_r && !pend_r && !out_valid_r), "not idle after reset")

endmodule

`default_nettype wire
